[sv/nac_pkg.sv]
// Shared types, sizes and status codes for the neighbor address cache.
`default_nettype none

package nac_pkg;

    localparam int ENTRIES  = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int IP_W     = 64;
    localparam int MAC_W    = 48;
    localparam int IFACE_W  = 4;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 64;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_HIT     = 3'd0;
    localparam t_status ST_MISS    = 3'd1;
    localparam t_status ST_ADDED   = 3'd2;
    localparam t_status ST_PRESENT = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    key_low;
        logic [IP_W-1:0]    key_high;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               action;
        logic [IP_W-1:0]    ip_high;
        logic [IP_W-1:0]    ip_low;
        logic [MAC_W-1:0]   mac_in;
        logic [IFACE_W-1:0] iface_in;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [MAC_W-1:0]   mac_out;
        logic [IFACE_W-1:0] iface_out;
        logic [SLOT_W-1:0]  slot;
    } t_result;

endpackage

`default_nettype wire

[sv/nac_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module nac_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 180,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[sv/nac_ctrl.sv]
// Scan sequencer: walks the entry memory, decides the result, appends on a learn miss unless full.
`default_nettype none

module nac_ctrl
    import nac_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_item_valid,
    output logic                  o_item_ready,
    input  wire t_item            i_item,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res,
    output logic      [IDX_W-1:0] o_rd_addr,
    input  wire logic [ENTRY_W-1:0] i_rd_data,
    output logic                  o_wr_en,
    output logic      [IDX_W-1:0] o_wr_addr,
    output logic      [ENTRY_W-1:0] o_wr_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    t_item            r_item, n_item;
    t_result          r_res, n_res;

    t_entry           rd_entry;
    t_entry           wr_entry;
    logic             issue;
    logic             match;

    assign rd_entry = t_entry'(i_rd_data);
    assign issue    = (r_rd_idx < r_fill);
    assign match    = r_pend && (rd_entry.key_high == r_item.ip_high)
                             && (rd_entry.key_low == r_item.ip_low);

    always_comb begin
        wr_entry.key_high = r_item.ip_high;
        wr_entry.key_low  = r_item.ip_low;
        wr_entry.mac      = r_item.mac_in;
        wr_entry.iface    = r_item.iface_in;
    end

    assign o_rd_addr = r_rd_idx[IDX_W-1:0];
    assign o_wr_addr = r_fill[IDX_W-1:0];
    assign o_wr_data = ENTRY_W'(wr_entry);
    assign o_res     = r_res;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_rd_idx     = r_rd_idx;
        n_pend       = r_pend;
        n_cmp_idx    = r_cmp_idx;
        n_item       = r_item;
        n_res        = r_res;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_wr_en      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_item   = i_item;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match) begin
                    // first matching entry wins; slot carries the entry index
                    n_res.slot = SLOT_W'(r_cmp_idx);
                    if (r_item.action) begin
                        n_res.status    = ST_PRESENT;
                        n_res.mac_out   = '0;
                        n_res.iface_out = '0;
                    end else begin
                        n_res.status    = ST_HIT;
                        n_res.mac_out   = rd_entry.mac;
                        n_res.iface_out = rd_entry.iface;
                    end
                    n_state = S_RESULT;
                end else if (!r_pend && !issue) begin
                    // every filled entry compared without a match
                    n_res.mac_out   = '0;
                    n_res.iface_out = '0;
                    n_res.slot      = '0;
                    if (!r_item.action) begin
                        n_res.status = ST_MISS;
                    end else if (r_fill == CNT_W'(ENTRIES)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        o_wr_en      = 1'b1;
                        n_res.status = ST_ADDED;
                        n_res.slot   = SLOT_W'(r_fill);
                        n_fill       = r_fill + CNT_W'(1);
                    end
                    n_state = S_RESULT;
                end else if (issue) begin
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                    n_cmp_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rd_idx <= n_rd_idx;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_item    <= n_item;
        r_res     <= n_res;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("fill count beyond capacity");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_fill == $past(r_fill) + CNT_W'(1)) && (r_state == S_RESULT))
        else $error("append did not advance fill count");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> (CNT_W'(r_cmp_idx) < r_fill))
        else $error("compared an unfilled entry");

    a_hit_is_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == ST_HIT || o_res.status == ST_MISS))
            |-> !r_item.action)
        else $error("lookup status on a learn item");

endmodule

`default_nettype wire

[sv/neighbor_address_cache.sv]
// Top level: IPv6 neighbor cache with stream ports and an output register.
// Scan: an accepted item is registered, then the memory is read one entry per cycle in
//   index order over the filled entries, stopping at the first hit; the result is registered.
// Throughput: one item at a time; the input is ready again in the cycle after its
//   predecessor's result moves to the output register.
// Reset: synchronous, active low; clears fill count and handshake state, not the entries.
`default_nettype none

module neighbor_address_cache
    import nac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // ip_high[63:0], ip_low[127:64], mac_in[175:128], iface_in[179:176], zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // action[0]: 0 lookup, 1 learn
    input  wire logic                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // mac_out[47:0], iface_out[51:48], slot[56:52], zero pad
    output logic      [OUT_DATA_W-1:0] o_m_tdata,
    // status[2:0]
    output logic      [STATUS_W-1:0]   o_m_tuser
);

    t_item               item;
    t_result             res;
    logic                res_valid;
    logic                res_ready;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    logic                r_out_valid;
    t_result             r_out;

    // unpack the slave item
    always_comb begin
        item.action   = i_s_tuser;
        item.ip_high  = i_s_tdata[IP_W-1:0];
        item.ip_low   = i_s_tdata[2*IP_W-1:IP_W];
        item.mac_in   = i_s_tdata[2*IP_W+MAC_W-1:2*IP_W];
        item.iface_in = i_s_tdata[2*IP_W+MAC_W+IFACE_W-1:2*IP_W+MAC_W];
    end

    nac_ram #(
        .DEPTH  (ENTRIES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    nac_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_tvalid),
        .o_item_ready (o_s_tready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    // load the output register when empty or when its item leaves this cycle
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = OUT_DATA_W'({r_out.slot, r_out.iface_out, r_out.mac_out});

endmodule

`default_nettype wire
